>>> rtl/slot_pool_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot pool allocator
// Shared concurrent-check helpers, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Types and constants shared by the slot pool allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spa_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int PTR_W          = 7;   // pointers and counts, capacity <= 127
  localparam int IDX_W          = 6;   // slot_index / granted_slot port width
  localparam int CFG_W          = 7;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } spa_cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_BAD_FREE = 2'd2
  } spa_err_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } spa_state_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [IDX_W-1:0] granted;
    spa_err_t         err;
    logic [PTR_W-1:0] used;
  } spa_result_t;

endpackage

>>> rtl/slot_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_unit
// Slot pool with an in-use bitmap in RAM, lowest-free pointer and use count.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  ---------------------------------
//  request   start & !busy                  cmd, slot_index
//  result    done (one-cycle strobe)        ok, granted_slot, error_code,
//                                           used_count
//  config    cfg_valid & cfg_ready          cfg_data (active_slots)
//
//  Sequence: the result strobe comes the cycle after the request is decided.
//    A failed allocate is decided in idle; a free first reads the bitmap RAM,
//    then checks and writes back. A successful allocate is decided in idle,
//    then scans upward for the next free slot, one bitmap entry per cycle
//    through the RAM read port, stopping at the first free slot or at capacity.
//  Reset and every config write run a clearing pass over all SLOT_COUNT
//    bitmap entries, one per cycle, with busy high; config writes restart it.
//  cfg_ready is high during the clearing pass and in idle while start is low.
//  The result side cannot stall; results are held only for their strobe.
//
`timescale 1ns / 1ps

module slot_pool_allocator_unit import spa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // request
  input  logic             start,
  output logic             busy,
  input  logic             cmd,
  input  logic [IDX_W-1:0] slot_index,
  // result
  output logic             done,
  output logic             ok,
  output logic [IDX_W-1:0] granted_slot,
  output logic [1:0]       error_code,
  output logic [PTR_W-1:0] used_count,
  // config
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_MAX = (1 << PTR_W) - 1;
  // the 7-bit register can never ask for more than PTR_MAX slots
  localparam logic [PTR_W-1:0] CAP_MAX =
    PTR_W'((SLOT_COUNT > PTR_MAX) ? PTR_MAX : SLOT_COUNT);

  logic [CFG_W-1:0] active_slots;
  logic [PTR_W-1:0] cap;
  logic             cfg_wr;
  spa_result_t      res;

  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  assign cfg_wr = cfg_valid && cfg_ready;
  // effective capacity, clamped to the built pool
  assign cap    = (active_slots < CAP_MAX) ? active_slots : CAP_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_slots <= cfg_data;
    end
  end

  // result register: strobe resets, payload loads with it
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      ok           <= res.ok;
      granted_slot <= res.granted;
      error_code   <= res.err;
      used_count   <= res.used;
    end
  end

  spa_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .slot_index (slot_index),
    .cfg_wr     (cfg_wr),
    .cap        (cap),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // in-use bitmap, one bit per slot
  spa_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> rtl/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Request sequencer: clear pass, allocate/free against the bitmap RAM, scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_pool_allocator_unit_defines.svh"

module spa_ctrl import spa_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cmd,
  input  logic [IDX_W-1:0] slot_index,
  input  logic             cfg_wr,
  input  logic [PTR_W-1:0] cap,
  output logic             busy,
  output logic             cfg_ready,
  output spa_result_t      res,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic             ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic             ram_rdata
);

  spa_state_t       state, state_next;
  logic [PTR_W-1:0] lowest_free;
  logic [PTR_W-1:0] slots_used;
  logic [PTR_W-1:0] scan_ptr;
  logic [IDX_W-1:0] req_idx;
  logic [AW-1:0]    clr_ptr;

  logic accept, is_alloc, alloc_full, alloc_go, free_bad, scan_end, clr_last;

  assign accept     = start && (state == ST_IDLE) && !cfg_wr;
  assign is_alloc   = (cmd == CMD_ALLOC);
  assign alloc_full = (slots_used >= cap) || (lowest_free >= cap);
  assign alloc_go   = accept && is_alloc && !alloc_full;
  assign free_bad   = ({1'b0, req_idx} >= cap) || !ram_rdata;
  // read data always belongs to scan_ptr while scanning
  assign scan_end   = (scan_ptr >= cap) || !ram_rdata;
  assign clr_last   = (clr_ptr == AW'(SLOT_COUNT - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (!cfg_wr && clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_wr) begin
          state_next = ST_CLEAR;
        end else if (alloc_go) begin
          state_next = ST_SCAN;
        end else if (accept && !is_alloc) begin
          state_next = ST_FREE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_FREE:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    // a pending request in idle wins over a config write
    cfg_ready   = (state == ST_CLEAR) || ((state == ST_IDLE) && !start);
    ram_we      = 1'b0;
    ram_waddr   = AW'(lowest_free);
    ram_wdata   = 1'b0;
    ram_raddr   = AW'(scan_ptr + 1'b1);
    res         = '0;
    res.err     = ERR_NONE;
    res.used    = slots_used;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
      end
      ST_IDLE: begin
        ram_raddr = is_alloc ? AW'(lowest_free + 1'b1) : AW'(slot_index);
        if (accept && is_alloc) begin
          res.valid = 1'b1;
          if (alloc_full) begin
            res.err = ERR_FULL;
          end else begin
            ram_we      = 1'b1;
            ram_wdata   = 1'b1;
            res.ok      = 1'b1;
            res.granted = IDX_W'(lowest_free);
            res.used    = slots_used + 1'b1;
          end
        end
      end
      ST_FREE: begin
        res.valid = 1'b1;
        ram_waddr = AW'(req_idx);
        if (free_bad) begin
          res.err = ERR_BAD_FREE;
        end else begin
          ram_we   = 1'b1;
          res.ok   = 1'b1;
          res.used = (slots_used != '0) ? slots_used - 1'b1 : slots_used;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_ptr     <= '0;
      lowest_free <= '0;
      slots_used  <= '0;
      scan_ptr    <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        clr_ptr     <= '0;
        lowest_free <= '0;
        slots_used  <= '0;
      end else begin
        case (state)
          ST_CLEAR: clr_ptr <= clr_ptr + 1'b1;
          ST_IDLE: begin
            if (accept) begin
              req_idx <= slot_index;
            end
            if (alloc_go) begin
              slots_used <= slots_used + 1'b1;
              scan_ptr   <= lowest_free + 1'b1;
            end
          end
          ST_SCAN: begin
            if (scan_end) begin
              lowest_free <= scan_ptr;
            end else begin
              scan_ptr <= scan_ptr + 1'b1;
            end
          end
          ST_FREE: begin
            if (!free_bad) begin
              if (slots_used != '0) begin
                slots_used <= slots_used - 1'b1;
              end
              if ({1'b0, req_idx} < lowest_free) begin
                lowest_free <= PTR_W'(req_idx);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  `SPA_ASSERT_NOW(a_used_le_cap, clk, rst, 1'b1, slots_used <= cap, "slots_used above capacity")
  `SPA_ASSERT_NOW(a_low_le_cap, clk, rst, 1'b1, lowest_free <= cap, "lowest_free above capacity")
  `SPA_ASSERT_NEXT(a_scan_start, clk, rst, alloc_go, (state == ST_SCAN) && (scan_ptr == $past(lowest_free) + 1'b1), "scan not started above grant")
  `SPA_ASSERT_NOW(a_scan_bound, clk, rst, state == ST_SCAN, scan_ptr <= cap, "scan ran past capacity")

endmodule

>>> verif/spa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_checker
// Watches the request, result and config channels of the slot pool allocator,
// keeps its own copy of the pool and compares every result in order.
// ----------------------------------------------------------------------------
module spa_checker import spa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             cmd,
  input  logic [IDX_W-1:0] slot_index,
  input  logic             done,
  input  logic             ok,
  input  logic [IDX_W-1:0] granted_slot,
  input  logic [1:0]       error_code,
  input  logic [PTR_W-1:0] used_count,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               grants,
  output int               full_refusals,
  output int               bad_frees
);

  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic             alloc;
    logic             ok;
    logic [IDX_W-1:0] granted;
    spa_err_t         err;
    logic [PTR_W-1:0] used;
  } grant_outcome_t;

  grant_outcome_t             expected_outcomes[$];
  bit [SLOT_COUNT_DEF-1:0]    occupied;
  int unsigned                next_free;
  int unsigned                slots_in_use;
  logic [CFG_W-1:0]           active_slots;

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < MAX_PRINTS)
      $display("MISMATCH @%0t %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic empty_pool();
    occupied     = '0;
    next_free    = 0;
    slots_in_use = 0;
  endtask

  task automatic predict_outcome(input logic c, input logic [IDX_W-1:0] idx,
                                 output grant_outcome_t r);
    int unsigned cap;
    int unsigned probe;
    cap = (active_slots < SLOT_COUNT_DEF) ? active_slots : SLOT_COUNT_DEF;
    r = '0;
    r.err = ERR_NONE;
    r.alloc = (c == CMD_ALLOC);
    if (c == CMD_ALLOC) begin
      if (slots_in_use >= cap || next_free >= cap) begin
        r.err = ERR_FULL;
      end else begin
        r.granted = next_free[IDX_W-1:0];
        r.ok = 1'b1;
        occupied[next_free] = 1'b1;
        slots_in_use++;
        probe = next_free;
        while (probe < cap && occupied[probe]) probe++;
        next_free = probe;
      end
    end else begin
      if (idx >= cap || !occupied[idx]) begin
        r.err = ERR_BAD_FREE;
      end else begin
        occupied[idx] = 1'b0;
        if (slots_in_use > 0) slots_in_use--;
        if (idx < next_free) next_free = idx;
        r.ok = 1'b1;
      end
    end
    r.used = slots_in_use[PTR_W-1:0];
  endtask

  always @(posedge clk) begin
    grant_outcome_t want;
    grant_outcome_t pred;
    if (rst) begin
      active_slots = ACTIVE_RESET;
      empty_pool();
      expected_outcomes.delete();
      mismatches     = 0;
      grants        <= 0;
      full_refusals <= 0;
      bad_frees     <= 0;
    end else begin
      // result first: a strobe belongs to an earlier request
      if (done === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result strobe, outstanding", 0, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
          if (granted_slot !== want.granted)
            report_mismatch("granted_slot", granted_slot, want.granted);
          if (error_code !== want.err)
            report_mismatch("error_code", error_code, want.err);
          if (used_count !== want.used)
            report_mismatch("used_count", used_count, want.used);
          if (want.alloc && want.ok) grants <= grants + 1;
          if (want.err == ERR_FULL) full_refusals <= full_refusals + 1;
          if (want.err == ERR_BAD_FREE) bad_frees <= bad_frees + 1;
        end
      end else if (done !== 1'b0) begin
        report_mismatch("done is unknown", 0, 0);
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        active_slots = cfg_data;
        empty_pool();
      end
      if (start && busy === 1'b0) begin
        predict_outcome(cmd, slot_index, pred);
        expected_outcomes.push_back(pred);
      end
    end
    outstanding <= expected_outcomes.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the slot pool allocator: a directed opener on the corner cases,
// then random allocate/free traffic over several pool capacities and idle
// rates. Prediction and compare live in spa_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import spa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000; // watchdog bound on the whole run
  localparam int SETTLE_CYCLES = 80;     // worst scan after the last strobe
  localparam int NUM_PHASES    = 9;
  localparam int BIAS_RUN      = 32;     // requests per fill/drain stretch

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             cmd;
  logic [IDX_W-1:0] slot_index;
  logic             done;
  logic             ok;
  logic [IDX_W-1:0] granted_slot;
  logic [1:0]       error_code;
  logic [PTR_W-1:0] used_count;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int grants;
  int full_refusals;
  int bad_frees;
  int requests_sent;
  int cycle_count;

  // phase table: capacity register value, sender idle percent, request count
  int phase_cfg[NUM_PHASES];
  int phase_idle[NUM_PHASES];
  int phase_len[NUM_PHASES];

  // 10 ns clock, first rising edge at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  slot_pool_allocator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .done         (done),
    .ok           (ok),
    .granted_slot (granted_slot),
    .error_code   (error_code),
    .used_count   (used_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  spa_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .done          (done),
    .ok            (ok),
    .granted_slot  (granted_slot),
    .error_code    (error_code),
    .used_count    (used_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .grants        (grants),
    .full_refusals (full_refusals),
    .bad_frees     (bad_frees)
  );

  // Present one request at a falling edge, after an optional random gap, and
  // hold it until a rising edge sees busy low. start stays high on return;
  // the next call (or drain_and_configure) decides its next value, so start
  // never gets two assignments in the same step.
  task automatic send_request(input spa_cmd_t c, input logic [IDX_W-1:0] idx,
                              input int idle_pct);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    slot_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
  endtask

  // Stop requesting, wait for every result, let a trailing scan finish, then
  // write the capacity register. The write also empties the pool.
  task automatic drain_and_configure(input logic [CFG_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // watchdog: a hung handshake or a lost result ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("slot_pool_allocator_unit verification failed");
    $finish;
  end

  initial begin
    int               cap;
    int               alloc_pct;
    int               p;
    int               n;
    bit               filling;
    logic [IDX_W-1:0] idx;
    spa_cmd_t         c;

    // capacity mix: extremes 0, 1 and 127 (clamps to 64), plus odd sizes
    phase_cfg  = '{64, 64,  8, 127,  1,  0, 33,  2, 100};
    phase_idle = '{ 0, 60, 21,   0, 60, 21, 21,  0,  60};
    phase_len  = '{200, 150, 120, 150, 40, 30, 150, 40, 170};

    requests_sent = 0;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_ALLOC;
    slot_index = '0;
    cfg_valid  = 1'b0;
    cfg_data   = ACTIVE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: reset capacity (64 slots) ----
    send_request(CMD_FREE,  6'd0,  0);   // free on an empty pool
    send_request(CMD_ALLOC, 6'h3F, 0);   // index is ignored on allocate -> 0
    send_request(CMD_ALLOC, 6'd0,  0);   // -> 1
    send_request(CMD_ALLOC, 6'd0,  0);   // -> 2
    send_request(CMD_FREE,  6'd1,  0);   // hole below the free pointer
    send_request(CMD_ALLOC, 6'd0,  0);   // refills the hole -> 1
    send_request(CMD_FREE,  6'h3F, 0);   // top slot, never used
    send_request(CMD_FREE,  6'd2,  0);
    send_request(CMD_FREE,  6'd2,  0);   // double free
    send_request(CMD_FREE,  6'd0,  0);
    send_request(CMD_ALLOC, 6'd0,  0);   // -> 0, scan steps over slot 1

    // ---- directed: two slots, fill to the top and overflow ----
    drain_and_configure(7'd2);
    send_request(CMD_ALLOC, 6'd0,  0);
    send_request(CMD_ALLOC, 6'd0,  0);   // last slot, pointer lands on capacity
    send_request(CMD_ALLOC, 6'd0,  0);   // pool full
    send_request(CMD_FREE,  6'd2,  0);   // at capacity: out of range
    send_request(CMD_FREE,  6'd0,  0);
    send_request(CMD_ALLOC, 6'd0,  0);
    send_request(CMD_FREE,  6'd1,  0);
    send_request(CMD_FREE,  6'd0,  0);

    // ---- directed: capacity zero, then above the built size ----
    drain_and_configure(7'd0);
    send_request(CMD_ALLOC, 6'd0,  0);   // full at once
    send_request(CMD_FREE,  6'd0,  0);   // nothing is in range
    drain_and_configure(7'd127);
    send_request(CMD_ALLOC, 6'd0,  0);
    send_request(CMD_FREE,  6'd0,  0);

    // ---- random phases ----
    // Stretches of mostly-allocate alternate with mostly-free so the pool
    // swings between nearly empty and full; frees mostly aim inside the
    // active range so a good share of them hit slots in use.
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_and_configure(phase_cfg[p][CFG_W-1:0]);
      cap = (phase_cfg[p] < SLOT_COUNT_DEF) ? phase_cfg[p] : SLOT_COUNT_DEF;
      filling = 1'b1;
      for (n = 0; n < phase_len[p]; n++) begin
        if (n % BIAS_RUN == BIAS_RUN - 1) filling = !filling;
        alloc_pct = filling ? 75 : 25;
        if ($urandom_range(0, 99) < alloc_pct) begin
          c   = CMD_ALLOC;
          idx = IDX_W'($urandom_range(0, 63));
        end else begin
          c = CMD_FREE;
          if (cap > 0 && $urandom_range(0, 99) < 85)
            idx = IDX_W'($urandom_range(0, cap - 1));
          else
            idx = IDX_W'($urandom_range(0, 63));
        end
        send_request(c, idx, phase_idle[p]);
      end
    end

    // ---- wind down ----
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over %0d capacity settings and idle rates 0/21/60%%",
             requests_sent, NUM_PHASES + 3);
    $display("Outcomes: %0d grants, %0d pool-full refusals, %0d rejected frees",
             grants, full_refusals, bad_frees);
    if (mismatches == 0)
      $display("slot_pool_allocator_unit verification clean");
    else
      $display("slot_pool_allocator_unit verification failed");
    $finish;
  end

endmodule
